### hdl/sbwm_pkg.sv
`timescale 1ns / 1ps
package sbwm_pkg;

  localparam int WORDS_PER_BLOCK = 16;
  localparam int WOFF_W          = $clog2(WORDS_PER_BLOCK);
  localparam int WOFF_LSB        = 2;
  localparam int TAG_LSB         = WOFF_LSB + WOFF_W;
  localparam int TAG_W           = 32 - TAG_LSB;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MISALIGNED = 2'd1,
    ST_FULL       = 2'd2
  } status_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic hit;
    logic free_ok;
  } lookup_t;

  typedef struct packed {
    logic alloc;
    logic release_slot;
  } slot_upd_t;

endpackage

### hdl/sbwm_if.sv
`timescale 1ns / 1ps
interface sbwm_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] address;
  logic [31:0] write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink (input valid, input operation, input address, input write_data,
                output ready);
endinterface

interface sbwm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  status;

  modport source (output valid, output read_data, output status, input ready);
  modport sink (input valid, input read_data, input status, output ready);
endinterface

### hdl/sbwm_ram.sv
`timescale 1ns / 1ps
module sbwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/sbwm_tags.sv
`timescale 1ns / 1ps
module sbwm_tags #(
  parameter int BLOCK_SLOTS = 64,
  parameter int SLOT_W      = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [sbwm_pkg::TAG_W-1:0] lookup_tag,
  output sbwm_pkg::lookup_t        look,
  output logic [SLOT_W-1:0]        sel_slot,
  input  sbwm_pkg::slot_upd_t      upd,
  input  logic [SLOT_W-1:0]        upd_slot,
  input  logic [sbwm_pkg::TAG_W-1:0] upd_tag
);
  import sbwm_pkg::*;

  logic [BLOCK_SLOTS-1:0] valid_r;
  logic [TAG_W-1:0]       tag_r [BLOCK_SLOTS];
  logic [SLOT_W-1:0]      match_slot;
  logic [SLOT_W-1:0]      free_slot;

  // Tags of valid slots are unique, so the match index is a plain OR.
  always_comb begin
    look       = '0;
    match_slot = '0;
    free_slot  = '0;
    for (int s = 0; s < BLOCK_SLOTS; s++) begin
      if (valid_r[s] && (tag_r[s] == lookup_tag)) begin
        look.hit   = 1'b1;
        match_slot = match_slot | SLOT_W'(s);
      end
    end
    // lowest free slot wins
    for (int s = BLOCK_SLOTS - 1; s >= 0; s--) begin
      if (!valid_r[s]) begin
        look.free_ok = 1'b1;
        free_slot    = SLOT_W'(s);
      end
    end
  end

  assign sel_slot = look.hit ? match_slot : free_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (upd.alloc) begin
      valid_r[upd_slot] <= 1'b1;
    end else if (upd.release_slot) begin
      valid_r[upd_slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.alloc) begin
      tag_r[upd_slot] <= upd_tag;
    end
  end

endmodule

### hdl/sparse_block_word_memory.sv
`timescale 1ns / 1ps
// Each item passes tag match, RAM read and update in turn, then its result is registered as valid;
// the update waits while an earlier result is unclaimed. The next item is taken once the previous
// one has finished its update (a write's word and mask written back): the read-modify-write sets the rate.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst_n low, synchronous): all slots freed, output empty; RAM contents are not cleared.
module sparse_block_word_memory #(
  parameter int BLOCK_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  sbwm_in_if.sink     in_ch,
  sbwm_out_if.source  out_ch
);
  import sbwm_pkg::*;

  localparam int SLOT_W     = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
  localparam int WORD_DEPTH = BLOCK_SLOTS * WORDS_PER_BLOCK;
  localparam int WADDR_W    = $clog2(WORD_DEPTH);

  state_t                     state_r, state_nxt;
  op_t                        op_r;
  logic [31:0]                addr_r;
  logic [31:0]                wdata_r;
  lookup_t                    look_r;
  logic [SLOT_W-1:0]          slot_r;
  logic                       out_valid_r;
  logic [31:0]                out_data_r;
  status_t                    out_status_r;

  lookup_t                    look;
  logic [SLOT_W-1:0]          sel_slot;
  slot_upd_t                  upd, upd_go;
  logic                       in_ready, rd_en, wb_go, in_acc;

  logic [WOFF_W-1:0]          woff;
  logic [WORDS_PER_BLOCK-1:0] bit_sel, mask_q, mask_nxt;
  logic [31:0]                word_q, rdata;
  status_t                    status;
  logic                       word_we, mask_we;
  logic [WADDR_W-1:0]         word_addr;

  assign in_acc = in_ch.valid & in_ready;

  sbwm_tags #(
    .BLOCK_SLOTS (BLOCK_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_tags (
    .clk        (clk),
    .rst_n      (rst_n),
    .lookup_tag (in_ch.address[31:TAG_LSB]),
    .look       (look),
    .sel_slot   (sel_slot),
    .upd        (upd_go),
    .upd_slot   (slot_r),
    .upd_tag    (addr_r[31:TAG_LSB])
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_READ;
      S_READ:   state_nxt = S_UPDATE;
      S_UPDATE: if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    wb_go    = 1'b0;
    case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_READ:   rd_en = 1'b1;
      S_UPDATE: wb_go = !out_valid_r || out_ch.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= op_t'(in_ch.operation);
      addr_r  <= in_ch.address;
      wdata_r <= in_ch.write_data;
      look_r  <= look;
      slot_r  <= sel_slot;
    end
  end

  assign woff      = addr_r[TAG_LSB-1:WOFF_LSB];
  assign bit_sel   = WORDS_PER_BLOCK'(1) << woff;
  assign word_addr = WADDR_W'({slot_r, woff});

  sbwm_ram #(
    .WIDTH (32),
    .DEPTH (WORD_DEPTH)
  ) u_word_ram (
    .clk   (clk),
    .we    (wb_go && word_we),
    .waddr (word_addr),
    .wdata (wdata_r),
    .re    (rd_en),
    .raddr (word_addr),
    .rdata (word_q)
  );

  sbwm_ram #(
    .WIDTH (WORDS_PER_BLOCK),
    .DEPTH (BLOCK_SLOTS)
  ) u_mask_ram (
    .clk   (clk),
    .we    (wb_go && mask_we),
    .waddr (slot_r),
    .wdata (mask_nxt),
    .re    (rd_en),
    .raddr (slot_r),
    .rdata (mask_q)
  );

  // Update step. A fresh block's mask is just the written bit, so the stale
  // RAM contents of a newly allocated slot never matter.
  always_comb begin
    rdata    = '0;
    status   = (addr_r[WOFF_LSB-1:0] != '0) ? ST_MISALIGNED : ST_OK;
    word_we  = 1'b0;
    mask_we  = 1'b0;
    mask_nxt = mask_q;
    upd      = '0;
    case (op_r)
      OP_READ: begin
        if (look_r.hit && ((mask_q & bit_sel) != '0)) rdata = word_q;
      end
      OP_WRITE: begin
        if (wdata_r != '0) begin
          if (look_r.hit || look_r.free_ok) begin
            word_we   = 1'b1;
            mask_we   = 1'b1;
            mask_nxt  = look_r.hit ? (mask_q | bit_sel) : bit_sel;
            upd.alloc = !look_r.hit;
          end else begin
            status = ST_FULL;
          end
        end else if (look_r.hit) begin
          // zero word: drop its mask bit, free the slot when nothing is left
          mask_we          = 1'b1;
          mask_nxt         = mask_q & ~bit_sel;
          upd.release_slot = (mask_nxt == '0);
        end
      end
      default: ;
    endcase
  end

  assign upd_go = wb_go ? upd : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      out_data_r   <= rdata;
      out_status_r <= status;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;
  assign out_ch.status    = out_status_r;

endmodule

### hdl/sbwm_checker.sv
`timescale 1ns / 1ps
module sbwm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status
);
  import sbwm_pkg::*;

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped or changed while stalled");

  // one item in flight: no new transaction right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // a result is present after the input transaction: this item's, or an earlier one still waiting
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##3 out_valid)
    else $error("no result after input transaction");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sparse_block_word_memory sbwm_checker u_sbwm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status)
);

### test/sparse_block_word_memory_tb.sv
`timescale 1ns / 1ps
module sparse_block_word_memory_tb;
  import sbwm_pkg::*;

  localparam int BLOCK_SLOTS = 64;
  localparam int TAG_POOL    = 80;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [31:0] read_data;
    status_t     status;
  } mem_result_t;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic clk;
  logic rst_n;

  sbwm_in_if  in_ch();
  sbwm_out_if out_ch();

  sparse_block_word_memory #(.BLOCK_SLOTS(BLOCK_SLOTS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the block store
  logic [TAG_W-1:0]           slot_tag [BLOCK_SLOTS];
  logic                       slot_used [BLOCK_SLOTS];
  logic [WORDS_PER_BLOCK-1:0] live_mask [BLOCK_SLOTS];
  logic [31:0]                word_copy [BLOCK_SLOTS*WORDS_PER_BLOCK];

  logic [TAG_W-1:0] tag_pool [TAG_POOL];
  mem_result_t      pending_results[$];
  int               mismatch_count = 0;
  int               cycle_count = 0;

  rx_mode_t rx_mode = RX_ALWAYS;
  int       hold_left = 0;
  bit       gaps_on = 1;
  int       burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Expected result of one access; updates the shadow store as the block would.
  function automatic mem_result_t apply_access(op_t op, logic [31:0] addr, logic [31:0] data);
    mem_result_t       r;
    logic [TAG_W-1:0]  tag;
    logic [WOFF_W-1:0] woff;
    int                s;
    int                idx;
    tag         = addr[31:TAG_LSB];
    woff        = addr[TAG_LSB-1:WOFF_LSB];
    r.read_data = '0;
    r.status    = (addr[1:0] != 2'b00) ? ST_MISALIGNED : ST_OK;
    s = -1;
    for (int i = 0; i < BLOCK_SLOTS; i++)
      if (s < 0 && slot_used[i] && slot_tag[i] == tag) s = i;
    if (op == OP_READ) begin
      if (s >= 0 && live_mask[s][woff]) r.read_data = word_copy[s*WORDS_PER_BLOCK + woff];
    end else if (data != 0) begin
      if (s < 0) begin
        for (int i = 0; i < BLOCK_SLOTS; i++)
          if (s < 0 && !slot_used[i]) s = i;
        if (s >= 0) begin
          slot_used[s] = 1'b1;
          slot_tag[s]  = tag;
          live_mask[s] = '0;
        end
      end
      if (s < 0) begin
        r.status = ST_FULL;
      end else begin
        idx            = s*WORDS_PER_BLOCK + woff;
        word_copy[idx] = data;
        live_mask[s][woff] = 1'b1;
      end
    end else if (s >= 0) begin
      idx                = s*WORDS_PER_BLOCK + woff;
      word_copy[idx]     = '0;
      live_mask[s][woff] = 1'b0;
      if (live_mask[s] == '0) slot_used[s] = 1'b0;
    end
    return r;
  endfunction

  // Address of a random word that currently holds a nonzero value
  function automatic bit pick_live_word(output logic [31:0] addr);
    int s;
    int w;
    int start_s;
    int start_w;
    addr    = '0;
    start_s = $urandom_range(0, BLOCK_SLOTS-1);
    start_w = $urandom_range(0, WORDS_PER_BLOCK-1);
    for (int i = 0; i < BLOCK_SLOTS; i++) begin
      s = (start_s + i) % BLOCK_SLOTS;
      if (slot_used[s]) begin
        for (int j = 0; j < WORDS_PER_BLOCK; j++) begin
          w = (start_w + j) % WORDS_PER_BLOCK;
          if (live_mask[s][w]) begin
            addr = {slot_tag[s], WOFF_W'(w), 2'b00};
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] pool_addr(bit misalign);
    logic [1:0] low;
    low = misalign ? 2'($urandom_range(1, 3)) : 2'b00;
    return {tag_pool[$urandom_range(0, TAG_POOL-1)], WOFF_W'($urandom_range(0, 15)), low};
  endfunction

  function automatic logic [31:0] nonzero_word();
    logic [31:0] d;
    if ($urandom_range(0, 4) == 0) d = 32'h1 << $urandom_range(0, 31);
    else d = $urandom;
    if (d == 0) d = 32'h1;
    return d;
  endfunction

  task automatic send_item(input op_t op, input logic [31:0] addr, input logic [31:0] data);
    if (gaps_on && burst_left <= 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.address    <= addr;
    in_ch.write_data <= data;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_access(op, addr, data));
  endtask

  // Receiver: ready pattern per mode, plus a counted hold-off
  initial begin
    logic [7:0] stall_pattern;
    logic [2:0] rx_phase;
    stall_pattern = 8'b1101_0110;
    rx_phase      = '0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ch.ready <= 1'b1;
          RX_RANDOM: out_ch.ready <= ($urandom_range(0, 99) < 60);
          default: begin
            out_ch.ready <= stall_pattern[rx_phase];
            rx_phase++;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_result
    mem_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: read_data=%h status=%0d", out_ch.read_data,
               out_ch.status);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.read_data !== exp_r.read_data) begin
          $error("read_data: expected %h, actual %h", exp_r.read_data, out_ch.read_data);
          mismatch_count++;
        end
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d (%s), actual %0d", exp_r.status, exp_r.status.name(),
                 out_ch.status);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_directed();
    rx_mode = RX_RANDOM;
    send_item(OP_READ,  32'h0000_0000, 32'h0);
    send_item(OP_READ,  32'hFFFF_FFFF, 32'h0);            // misaligned, empty memory
    send_item(OP_WRITE, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
    send_item(OP_READ,  32'hFFFF_FFFC, 32'h0);
    send_item(OP_READ,  32'hFFFF_FFFE, 32'h0);            // same word, truncated offset
    send_item(OP_WRITE, 32'h0000_0000, 32'h0000_0001);
    send_item(OP_WRITE, 32'h0000_003C, 32'h8000_0000);
    send_item(OP_READ,  32'h0000_0000, 32'h0);
    send_item(OP_READ,  32'h0000_003C, 32'h0);
    send_item(OP_READ,  32'h0000_0020, 32'h0);            // live block, word never set
    send_item(OP_WRITE, 32'h0000_0013, 32'hA5A5_A5A5);    // misaligned write to word 4
    send_item(OP_READ,  32'h0000_0010, 32'h0);
    send_item(OP_WRITE, 32'h1234_5678, 32'h0);            // zero write, block absent
    send_item(OP_WRITE, 32'h8765_4321, 32'h0);
    send_item(OP_WRITE, 32'h0000_0000, 32'h0);
    send_item(OP_READ,  32'h0000_0000, 32'h0);
    send_item(OP_WRITE, 32'h0000_003C, 32'h0);
    send_item(OP_WRITE, 32'h0000_0011, 32'h0);            // last word cleared, block freed
    send_item(OP_READ,  32'h0000_0010, 32'h0);
    send_item(OP_WRITE, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_READ,  32'hFFFF_FFFC, 32'h0);
    send_item(OP_READ,  32'h0000_0040, 32'hDEAD_BEEF);    // read ignores write_data
  endtask

  task automatic test_pool_full();
    logic [31:0] addr;
    rx_mode = RX_PATTERN;
    // More distinct blocks than slots; the tail ones must report a full pool
    for (int i = 0; i < 70; i++) begin
      addr = {tag_pool[i], WOFF_W'(i), (i == 67) ? 2'b10 : 2'b00};
      send_item(OP_WRITE, addr, nonzero_word());
    end
    send_item(OP_WRITE, {tag_pool[10], WOFF_W'(10), 2'b00}, 32'h0);
    send_item(OP_WRITE, {tag_pool[75], WOFF_W'(3), 2'b00}, nonzero_word());
    send_item(OP_READ,  {tag_pool[75], WOFF_W'(3), 2'b00}, 32'h0);
    send_item(OP_READ,  {tag_pool[68], WOFF_W'(4), 2'b00}, 32'h0);
    send_item(OP_WRITE, {tag_pool[76], WOFF_W'(0), 2'b00}, nonzero_word());
    while (pick_live_word(addr)) send_item(OP_WRITE, addr, 32'h0);
  endtask

  // Output held off while the sender keeps offering: the block must stall its input
  task automatic test_output_stall();
    logic [31:0] addr;
    gaps_on   = 0;
    rx_mode   = RX_ALWAYS;
    hold_left = 300;
    for (int i = 0; i < 16; i++) begin
      addr = pool_addr(0);
      send_item(OP_WRITE, addr, nonzero_word());
      send_item(OP_READ, addr, 32'h0);
    end
    gaps_on = 1;
  endtask

  task automatic test_random_mix(input int n, input rx_mode_t mode, input int read_pct,
                                 input int write_pct);
    logic [31:0] addr;
    int          r;
    rx_mode = mode;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        // noise: anything at all
        send_item(op_t'($urandom_range(0, 1)), $urandom,
                  ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom);
      end else if (r < 5 + read_pct) begin
        if ($urandom_range(0, 9) < 6 && pick_live_word(addr)) begin
          if ($urandom_range(0, 9) == 0) addr[1:0] = 2'($urandom_range(1, 3));
        end else begin
          addr = pool_addr($urandom_range(0, 9) == 0);
        end
        send_item(OP_READ, addr, $urandom);
      end else if (r < 5 + read_pct + write_pct) begin
        send_item(OP_WRITE, pool_addr($urandom_range(0, 9) == 0), nonzero_word());
      end else begin
        if ($urandom_range(0, 9) < 8 && pick_live_word(addr)) begin
          if ($urandom_range(0, 9) == 0) addr[1:0] = 2'($urandom_range(1, 3));
        end else begin
          addr = pool_addr($urandom_range(0, 9) == 0);
        end
        send_item(OP_WRITE, addr, 32'h0);
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_READ;
    in_ch.address    = '0;
    in_ch.write_data = '0;
    for (int s = 0; s < BLOCK_SLOTS; s++) begin
      slot_tag[s]  = '0;
      slot_used[s] = 1'b0;
      live_mask[s] = '0;
    end
    for (int i = 0; i < BLOCK_SLOTS*WORDS_PER_BLOCK; i++) word_copy[i] = '0;
    // Distinct tags: low 7 bits are the index, upper bits random
    for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = {19'($urandom), 7'(i)};
    tag_pool[0]            = '0;
    tag_pool[TAG_POOL - 1] = '1;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_pool_full();
    test_output_stall();
    test_random_mix(250, RX_RANDOM, 30, 50);
    test_random_mix(250, RX_PATTERN, 30, 20);
    test_random_mix(250, RX_ALWAYS, 35, 35);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/sbwm_pkg.sv
hdl/sbwm_if.sv
hdl/sbwm_ram.sv
hdl/sbwm_tags.sv
hdl/sparse_block_word_memory.sv
hdl/sbwm_checker.sv
test/sparse_block_word_memory_tb.sv
